### hdl/nfcrp_pkg.sv
// ---------------------------------------------------------------------------
// NFC response frame parser package
// Shared event codes, field widths and the item and result structures.
// ---------------------------------------------------------------------------
package nfcrp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;

  localparam logic [ByteW-1:0] KeepLimitReset = 8'hFF;
  localparam logic [ByteW-1:0] PreZero        = 8'h00;
  localparam logic [ByteW-1:0] PreStart       = 8'hFF;
  localparam logic [ByteW-1:0] HdrBytes       = 8'd2;

  typedef enum logic [KindW-1:0] {
    EV_HEADER  = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_TRAILER = 3'd2,
    EV_DONE    = 3'd3,
    EV_BAD_PRE = 3'd4,
    EV_BAD_LEN = 3'd5,
    EV_SHORT   = 3'd6
  } event_kind_t;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             frame_start;
  } rx_item_t;

  typedef struct packed {
    event_kind_t      event_kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] payload_index;
    logic             kept;
    logic [ByteW-1:0] payload_length;
    logic             frame_end;
  } result_t;

  // Handshake between the input stage and the parser.
  typedef struct packed {
    logic valid;
  } stage_ctl_t;

endpackage

### hdl/nfc_response_frame_parser_top.sv
// ---------------------------------------------------------------------------
// NFC response frame parser
// Parses a controller response frame byte by byte and reports each payload.
// ---------------------------------------------------------------------------
//  Channel | Ports                                      | Direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, in_rx_byte, ...        | receive
//  out     | out_valid, out_stall, out_event_kind, ...  | send
//  cfg     | cfg_wr_en, cfg_wr_data (keep limit)        | receive
//
// Each item gives exactly one result, presented on the output once the item has
// moved from the input register into the result register.
// One item per cycle is sustained while the output does not stall; the phase
// machine step sits between the input register and the result register.
// Reset sets the keep limit to 255 and waits for a frame start.
// A stalled result holds; the input register still takes one more item.
module nfc_response_frame_parser_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [nfcrp_pkg::ByteW-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [nfcrp_pkg::ByteW-1:0] in_rx_byte,
  input  logic                        in_frame_start,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nfcrp_pkg::KindW-1:0] out_event_kind,
  output logic [nfcrp_pkg::ByteW-1:0] out_payload_byte,
  output logic [nfcrp_pkg::ByteW-1:0] out_payload_index,
  output logic                        out_kept,
  output logic [nfcrp_pkg::ByteW-1:0] out_payload_length,
  output logic                        out_frame_end
);
  import nfcrp_pkg::*;

  logic [ByteW-1:0] keep_limit_r;
  rx_item_t         in_item, item;
  logic             item_valid;
  logic             advance;
  stage_ctl_t       ctl;
  result_t          result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_limit_r <= KeepLimitReset;
    end else if (cfg_wr_en) begin
      keep_limit_r <= cfg_wr_data;
    end
  end

  assign in_item.rx_byte     = in_rx_byte;
  assign in_item.frame_start = in_frame_start;

  nfcrp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  assign ctl.valid = item_valid;

  nfcrp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_in     (ctl),
    .advance    (advance),
    .item       (item),
    .keep_limit (keep_limit_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign out_event_kind     = result.event_kind;
  assign out_payload_byte   = result.payload_byte;
  assign out_payload_index  = result.payload_index;
  assign out_kept           = result.kept;
  assign out_payload_length = result.payload_length;
  assign out_frame_end      = result.frame_end;

`ifndef SYNTHESIS
  // Only a payload event may carry the kept flag.
  a_kept_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kept) |-> (out_event_kind == EV_PAYLOAD))
    else $error("kept flag on a non-payload result");

  // A done event always closes the frame; a payload event never does.
  a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == EV_DONE) |-> out_frame_end)
    else $error("done result without frame end");

  a_payload_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == EV_PAYLOAD) |-> !out_frame_end)
    else $error("payload result marked as frame end");

  // An item waiting in the input register moves on unless the result stalls.
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall) |-> (out_valid && out_stall))
    else $error("input stalled while the result register was free");
`endif

endmodule

### hdl/nfcrp_in_stage.sv
// ---------------------------------------------------------------------------
// NFC response frame parser input stage
// Holds one received item until the parser moves it into the result register.
// ---------------------------------------------------------------------------
module nfcrp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  nfcrp_pkg::rx_item_t in_item,
  input  logic               advance,
  output logic               item_valid,
  output nfcrp_pkg::rx_item_t item
);
  import nfcrp_pkg::*;

  logic     valid_r, valid_nxt;
  rx_item_t item_r;
  logic     accept;

  assign in_stall  = valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign valid_nxt = accept ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### hdl/nfcrp_parser.sv
// ---------------------------------------------------------------------------
// NFC response frame parser core
// Frame phase machine, length and payload counters, and the result register.
// ---------------------------------------------------------------------------
module nfcrp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  nfcrp_pkg::stage_ctl_t ctl_in,
  output logic                advance,
  input  nfcrp_pkg::rx_item_t item,
  input  logic [nfcrp_pkg::ByteW-1:0] keep_limit,
  output logic                out_valid,
  input  logic                out_stall,
  output nfcrp_pkg::result_t  result
);
  import nfcrp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_PRE1 = 4'd1,
    PH_PRE2 = 4'd2,
    PH_LEN  = 4'd3,
    PH_LCS  = 4'd4,
    PH_TFI  = 4'd5,
    PH_CODE = 4'd6,
    PH_PAY  = 4'd7,
    PH_DCS  = 4'd8,
    PH_POST = 4'd9
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] frame_len_r, frame_len_nxt;
  logic [ByteW-1:0] byte_count_r, byte_count_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          result_r, result_nxt;
  logic [ByteW-1:0] pay_len;
  logic [ByteW-1:0] count_inc;
  logic [ByteW-1:0] lcs_sum;

  assign advance   = ctl_in.valid && (!out_valid_r || !out_stall);
  assign pay_len   = frame_len_r - HdrBytes;
  assign count_inc = byte_count_r + 8'd1;
  assign lcs_sum   = frame_len_r + item.rx_byte;

  always_comb begin
    phase_nxt      = phase_r;
    frame_len_nxt  = frame_len_r;
    byte_count_nxt = byte_count_r;
    result_nxt     = '0;
    result_nxt.event_kind = EV_HEADER;

    if (item.frame_start) begin
      // A start flag drops any open frame and parses this byte as preamble.
      if (item.rx_byte != PreZero) begin
        phase_nxt = PH_IDLE;
        result_nxt.event_kind = EV_BAD_PRE;
        result_nxt.frame_end  = 1'b1;
      end else begin
        phase_nxt = PH_PRE1;
      end
    end else begin
      case (phase_r)
        PH_PRE1: begin
          if (item.rx_byte != PreZero) begin
            phase_nxt = PH_IDLE;
            result_nxt.event_kind = EV_BAD_PRE;
            result_nxt.frame_end  = 1'b1;
          end else begin
            phase_nxt = PH_PRE2;
          end
        end
        PH_PRE2: begin
          if (item.rx_byte != PreStart) begin
            phase_nxt = PH_IDLE;
            result_nxt.event_kind = EV_BAD_PRE;
            result_nxt.frame_end  = 1'b1;
          end else begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          frame_len_nxt = item.rx_byte;
          phase_nxt     = PH_LCS;
        end
        PH_LCS: begin
          if (lcs_sum != 8'd0) begin
            phase_nxt = PH_IDLE;
            result_nxt.event_kind = EV_BAD_LEN;
            result_nxt.frame_end  = 1'b1;
          end else if (frame_len_r < HdrBytes) begin
            phase_nxt = PH_IDLE;
            result_nxt.event_kind = EV_SHORT;
            result_nxt.frame_end  = 1'b1;
          end else begin
            phase_nxt = PH_TFI;
          end
        end
        PH_TFI: begin
          phase_nxt = PH_CODE;
        end
        PH_CODE: begin
          byte_count_nxt = '0;
          phase_nxt = (frame_len_r == HdrBytes) ? PH_DCS : PH_PAY;
        end
        PH_PAY: begin
          result_nxt.event_kind    = EV_PAYLOAD;
          result_nxt.payload_byte  = item.rx_byte;
          result_nxt.payload_index = byte_count_r;
          result_nxt.kept          = byte_count_r < keep_limit;
          byte_count_nxt           = count_inc;
          if (count_inc >= pay_len) begin
            phase_nxt = PH_DCS;
          end
        end
        PH_DCS: begin
          phase_nxt = PH_POST;
          result_nxt.event_kind = EV_TRAILER;
        end
        PH_POST: begin
          phase_nxt = PH_IDLE;
          result_nxt.event_kind     = EV_DONE;
          result_nxt.payload_length = pay_len;
          result_nxt.frame_end      = 1'b1;
        end
        default: begin
          // A stray byte with no frame open.
          phase_nxt = PH_IDLE;
          result_nxt.event_kind = EV_SHORT;
        end
      endcase
    end
  end

  assign out_valid_nxt = advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      frame_len_r  <= '0;
      byte_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        phase_r      <= phase_nxt;
        frame_len_r  <= frame_len_nxt;
        byte_count_r <= byte_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the NFC response frame parser
// Feeds response frames byte by byte (good, corrupted, cut short and pure
// noise), predicts every parser event and compares each result field by
// field, under random gaps and stalls and several keep limit settings.
// ---------------------------------------------------------------------------
module tb_top;
  import nfcrp_pkg::*;

  localparam int CycleLimit = 400000;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE1, S_PRE2, S_LEN, S_LCS, S_TFI, S_CODE, S_PAY, S_DCS, S_POST
  } parse_phase_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [ByteW-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] in_rx_byte = '0;
  logic             in_frame_start = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [KindW-1:0] out_event_kind;
  logic [ByteW-1:0] out_payload_byte;
  logic [ByteW-1:0] out_payload_index;
  logic             out_kept;
  logic [ByteW-1:0] out_payload_length;
  logic             out_frame_end;

  // Parser state as predicted by the bench.
  parse_phase_t     phase_q;
  logic [ByteW-1:0] len_q;
  logic [ByteW-1:0] cnt_q;
  logic [ByteW-1:0] keep_q;

  rx_item_t pending_items[$];
  result_t  expected_events[$];
  int       items_queued = 0;
  int       err_count = 0;
  int       cycle_count = 0;
  bit       src_gaps = 1'b0;
  bit       sink_stalls = 1'b0;

  // Sender side.
  rx_item_t next_item;
  logic     drive_valid;
  int       gap_left = 0;

  // Receiver side.
  result_t want;
  int      stall_left = 0;
  int      results_seen = 0;
  bit      long_hold_done = 1'b0;

  nfc_response_frame_parser_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .in_frame_start     (in_frame_start),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_kind     (out_event_kind),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_kept           (out_kept),
    .out_payload_length (out_payload_length),
    .out_frame_end      (out_frame_end)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Advances the predicted parser by one byte and returns its event.
  function automatic result_t parse_byte(input logic [ByteW-1:0] b, input logic st);
    result_t          r;
    logic [ByteW-1:0] lsum;
    r = '0;
    r.event_kind = EV_HEADER;
    lsum = len_q + b;
    if (st) begin
      if (b != PreZero) begin
        phase_q = S_IDLE;
        r.event_kind = EV_BAD_PRE;
        r.frame_end = 1'b1;
      end else begin
        phase_q = S_PRE1;
      end
      return r;
    end
    case (phase_q)
      S_PRE1: begin
        if (b != PreZero) begin
          phase_q = S_IDLE;
          r.event_kind = EV_BAD_PRE;
          r.frame_end = 1'b1;
        end else begin
          phase_q = S_PRE2;
        end
      end
      S_PRE2: begin
        if (b != PreStart) begin
          phase_q = S_IDLE;
          r.event_kind = EV_BAD_PRE;
          r.frame_end = 1'b1;
        end else begin
          phase_q = S_LEN;
        end
      end
      S_LEN: begin
        len_q = b;
        phase_q = S_LCS;
      end
      S_LCS: begin
        if (lsum != '0) begin
          phase_q = S_IDLE;
          r.event_kind = EV_BAD_LEN;
          r.frame_end = 1'b1;
        end else if (len_q < HdrBytes) begin
          phase_q = S_IDLE;
          r.event_kind = EV_SHORT;
          r.frame_end = 1'b1;
        end else begin
          phase_q = S_TFI;
        end
      end
      S_TFI: phase_q = S_CODE;
      S_CODE: begin
        cnt_q = '0;
        phase_q = (len_q == HdrBytes) ? S_DCS : S_PAY;
      end
      S_PAY: begin
        r.event_kind = EV_PAYLOAD;
        r.payload_byte = b;
        r.payload_index = cnt_q;
        r.kept = (cnt_q < keep_q);
        cnt_q = cnt_q + 8'd1;
        if (cnt_q >= len_q - HdrBytes) phase_q = S_DCS;
      end
      S_DCS: begin
        r.event_kind = EV_TRAILER;
        phase_q = S_POST;
      end
      S_POST: begin
        r.event_kind = EV_DONE;
        r.payload_length = len_q - HdrBytes;
        r.frame_end = 1'b1;
        phase_q = S_IDLE;
      end
      default: begin
        r.event_kind = EV_SHORT;
        phase_q = S_IDLE;
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!src_gaps || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report(input string msg);
    err_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // Sender: a held item stays on the port until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      drive_valid = in_valid && in_stall;
      if (in_valid && !in_stall)
        expected_events.push_back(parse_byte(in_rx_byte, in_frame_start));
      if (!drive_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_rx_byte <= next_item.rx_byte;
          in_frame_start <= next_item.frame_start;
          drive_valid = 1'b1;
          gap_left = pick_gap();
        end
      end
      in_valid <= drive_valid;
    end
  end

  // Receiver: checks each result and decides the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          report($sformatf("unexpected result, kind %0d", out_event_kind));
        end else begin
          want = expected_events.pop_front();
          if (out_event_kind !== want.event_kind)
            report($sformatf("event_kind %0d, want %0d", out_event_kind, want.event_kind));
          if (out_payload_byte !== want.payload_byte)
            report($sformatf("payload_byte %0h, want %0h", out_payload_byte,
                             want.payload_byte));
          if (out_payload_index !== want.payload_index)
            report($sformatf("payload_index %0d, want %0d", out_payload_index,
                             want.payload_index));
          if (out_kept !== want.kept)
            report($sformatf("kept %0b, want %0b", out_kept, want.kept));
          if (out_payload_length !== want.payload_length)
            report($sformatf("payload_length %0d, want %0d", out_payload_length,
                             want.payload_length));
          if (out_frame_end !== want.frame_end)
            report($sformatf("frame_end %0b, want %0b", out_frame_end, want.frame_end));
        end
      end
      // One long hold while the sender is busy, so that the parser backs up.
      if (!long_hold_done && results_seen >= 150 && in_valid) begin
        stall_left = 80;
        long_hold_done = 1'b1;
      end else if (stall_left == 0 && sink_stalls) begin
        case ($urandom_range(0, 99)) inside
          [0:14]:  stall_left = $urandom_range(1, 3);
          [15:16]: stall_left = $urandom_range(10, 40);
          default: stall_left = 0;
        endcase
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_byte(input logic [ByteW-1:0] b, input logic st);
    rx_item_t it;
    it.rx_byte = b;
    it.frame_start = st;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Queues a frame with the given LEN and LCS; cut limits the bytes sent
  // (negative sends the whole frame).
  task automatic queue_frame(input logic [ByteW-1:0] len, input logic [ByteW-1:0] lcs,
                             input int cut);
    logic [ByteW-1:0] fb[$];
    int               n;
    fb = {PreZero, PreZero, PreStart, len, lcs};
    if (len >= HdrBytes && 8'(len + lcs) == 8'h00) begin
      for (int i = 0; i < int'(len) + 2; i++) fb.push_back(8'($urandom_range(0, 255)));
    end
    n = (cut >= 0 && cut < fb.size()) ? cut : fb.size();
    for (int i = 0; i < n; i++) queue_byte(fb[i], i == 0);
  endtask

  task automatic queue_bad_preamble();
    int pos;
    pos = $urandom_range(0, 2);
    if (pos == 0) begin
      queue_byte(8'($urandom_range(1, 255)), 1'b1);
    end else begin
      queue_byte(PreZero, 1'b1);
      if (pos == 1) begin
        queue_byte(8'($urandom_range(1, 255)), 1'b0);
      end else begin
        queue_byte(PreZero, 1'b0);
        queue_byte(8'($urandom_range(0, 254)), 1'b0);
      end
    end
  endtask

  task automatic random_traffic(input int n_items, input bit allow_big);
    int               stop;
    int               r;
    logic [ByteW-1:0] len;
    stop = items_queued + n_items;
    while (items_queued < stop) begin
      r = $urandom_range(0, 99);
      len = 8'($urandom_range(2, 12));
      if (allow_big && $urandom_range(0, 99) < 3) len = 8'($urandom_range(200, 255));
      if (r < 60) begin
        queue_frame(len, 8'h00 - len, -1);
      end else if (r < 70) begin
        queue_frame(len, 8'h00 - len + 8'($urandom_range(1, 255)), -1);
      end else if (r < 75) begin
        len = 8'($urandom_range(0, 1));
        queue_frame(len, 8'h00 - len, -1);
      end else if (r < 82) begin
        queue_bad_preamble();
      end else if (r < 90) begin
        // Cut short; the next sequence usually restarts the parser.
        queue_frame(len, 8'h00 - len, $urandom_range(1, int'(len) + 6));
      end else begin
        repeat ($urandom_range(1, 4))
          queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // Waits until every queued item has been taken and every result checked.
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_keep(input logic [ByteW-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    keep_q = v;
    @(negedge clk);
  endtask

  initial begin
    phase_q = S_IDLE;
    len_q = '0;
    cnt_q = '0;
    keep_q = KeepLimitReset;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames at the reset keep limit, with no idling.
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hA5, 1'b1);
    queue_byte(PreZero, 1'b1);
    queue_byte(PreStart, 1'b0);
    queue_byte(PreZero, 1'b1);
    queue_byte(PreZero, 1'b0);
    queue_byte(PreZero, 1'b0);
    queue_frame(8'h05, 8'h00, -1);
    queue_frame(8'h01, 8'hFF, -1);
    queue_frame(8'h03, 8'hFD, 6);
    queue_frame(8'h02, 8'hFE, -1);
    drain();

    write_keep(8'h00);
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    queue_frame(8'hFF, 8'h01, -1);
    random_traffic(30, 1'b1);
    drain();

    write_keep(8'hFF);
    queue_frame(8'hFF, 8'h01, -1);
    random_traffic(30, 1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_keep((ph == 3) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 12)));
      src_gaps = $urandom_range(0, 1);
      sink_stalls = $urandom_range(0, 1);
      random_traffic(30, ph == 3);
      drain();
    end

    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    random_traffic(30, 1'b1);
    drain();
    repeat (10) @(negedge clk);

    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/nfcrp_pkg.sv
hdl/nfcrp_in_stage.sv
hdl/nfcrp_parser.sv
hdl/nfc_response_frame_parser_top.sv
bench/tb_top.sv
